### src/grpc_pkg.sv
// Shared constants, types and helpers for the grid range-add prefix-count block.
package grpc_pkg;

  // Grid geometry.
  localparam int ROWS   = 64;
  localparam int COLS   = 64;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;

  // Field widths of a transaction.
  localparam int FUNC_W = 2;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 13;

  // Corner coordinates are one wider than a field so that end + 1 fits.
  localparam int CRD_W  = IDX_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Function codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CRD_W-1:0]         crd_t;

  // Linear address of grid position (r, c), row major.
  function automatic addr_t grid_addr(input crd_t r, input crd_t c);
    int lin;
    lin = int'(r) * COLS + int'(c);
    return ADDR_W'(lin);
  endfunction

endpackage

### src/grid_range_add_prefix_count_core.sv
// Load: a single write to the cell memory. Update: a read and a write per corner inside the grid
// and a single skip step per corner outside it; a rejected rectangle leaves the block idle.
// Finish: read, row prefix, column prefix and cell update steps per cell; the count strobe follows in the next cycle.
// Rate is set by the single shared saturating adder and one read-modify-write per step.
// After reset the difference memory is cleared, one entry a cycle, with busy high;
// the result strobe cannot be stalled by the receiver.
module grid_range_add_prefix_count_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [grpc_pkg::FUNC_W-1:0]  func_i,
  input  logic [grpc_pkg::IDX_W-1:0]   row_i,
  input  logic [grpc_pkg::IDX_W-1:0]   col_i,
  input  logic [grpc_pkg::IDX_W-1:0]   row_end_i,
  input  logic [grpc_pkg::IDX_W-1:0]   col_end_i,
  input  logic [grpc_pkg::VAL_W-1:0]   board_value_i,
  input  logic [grpc_pkg::VAL_W-1:0]   degree_i,
  input  logic                         is_attack_i,
  output logic                         done_o,
  output logic [grpc_pkg::CNT_W-1:0]   positive_count_o
);
  import grpc_pkg::*;

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_UPD_RD   = 4'd2;
  localparam logic [3:0] ST_UPD_WR   = 4'd3;
  localparam logic [3:0] ST_FIN_RD   = 4'd4;
  localparam logic [3:0] ST_FIN_ROW  = 4'd5;
  localparam logic [3:0] ST_FIN_COL  = 4'd6;
  localparam logic [3:0] ST_FIN_CELL = 4'd7;

  localparam addr_t            LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [COL_AW-1:0] LAST_COL = COL_AW'(COLS - 1);

  logic [3:0]        state_q, state_d;
  addr_t             walk_q, walk_d;
  logic [COL_AW-1:0] col_idx_q, col_idx_d;
  logic              first_row_q, first_row_d;
  logic [1:0]        corner_q, corner_d;
  crd_t              r1_q, c1_q, r2p_q, c2p_q;
  data_t             delta_q;
  data_t             row_acc_q, row_acc_d;
  data_t             col_val_q, col_val_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  result_q, result_d;
  logic              done_q, done_d;

  logic  accept;
  logic  load_ok, upd_ok;
  crd_t  corner_row, corner_col;
  logic  corner_ok;
  logic  corner_neg;
  data_t deg_ext;

  // Shared adder operands and result.
  data_t alu_a, alu_b, alu_sum;

  // Memory ports.
  logic  diff_we, diff_re;
  addr_t diff_waddr, diff_raddr;
  data_t diff_wdata, diff_rdata;
  logic  cell_we, cell_re;
  addr_t cell_waddr;
  data_t cell_wdata, cell_rdata;
  logic  line_we, line_re;
  data_t line_rdata;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Range checks on the incoming transaction.
  assign load_ok = (int'(row_i) < ROWS) && (int'(col_i) < COLS);
  assign upd_ok  = (row_i <= row_end_i) && (col_i <= col_end_i) &&
                   (int'(row_end_i) < ROWS) && (int'(col_end_i) < COLS);

  // Corner order: (r1,c1) +, (r1,c2+1) -, (r2+1,c1) -, (r2+1,c2+1) +.
  assign corner_row = corner_q[1] ? r2p_q : r1_q;
  assign corner_col = corner_q[0] ? c2p_q : c1_q;
  assign corner_ok  = (int'(corner_row) < ROWS) && (int'(corner_col) < COLS);
  assign corner_neg = is_attack_i ^ 1'b0;
  assign deg_ext    = data_t'({{(DATA_W-VAL_W){1'b0}}, degree_i});

  // Shared saturating adder, operands chosen by the sequencer step.
  always_comb begin
    alu_a = diff_rdata;
    alu_b = (corner_q[0] ^ corner_q[1]) ? -delta_q : delta_q;
    unique case (state_q)
      ST_FIN_ROW: begin
        alu_a = diff_rdata;
        alu_b = (col_idx_q == '0) ? '0 : row_acc_q;
      end
      ST_FIN_COL: begin
        alu_a = row_acc_q;
        alu_b = first_row_q ? '0 : line_rdata;
      end
      ST_FIN_CELL: begin
        alu_a = cell_rdata;
        alu_b = col_val_q;
      end
      default: begin
        alu_a = diff_rdata;
        alu_b = (corner_q[0] ^ corner_q[1]) ? -delta_q : delta_q;
      end
    endcase
  end

  grpc_sat_add u_sat_add (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum)
  );

  // Sequencer and memory control.
  always_comb begin
    state_d     = state_q;
    walk_d      = walk_q;
    col_idx_d   = col_idx_q;
    first_row_d = first_row_q;
    corner_d    = corner_q;
    row_acc_d   = row_acc_q;
    col_val_d   = col_val_q;
    count_d     = count_q;
    result_d    = result_q;
    done_d      = 1'b0;

    diff_we     = 1'b0;
    diff_re     = 1'b0;
    diff_waddr  = walk_q;
    diff_raddr  = walk_q;
    diff_wdata  = '0;
    cell_we     = 1'b0;
    cell_re     = 1'b0;
    cell_waddr  = walk_q;
    cell_wdata  = alu_sum;
    line_we     = 1'b0;
    line_re     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        diff_we = 1'b1;
        walk_d  = walk_q + 1'b1;
        if (walk_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_LOAD: begin
              cell_we    = load_ok;
              cell_waddr = grid_addr(crd_t'(row_i), crd_t'(col_i));
              cell_wdata = data_t'({{(DATA_W-VAL_W){1'b0}}, board_value_i});
            end
            FUNC_UPDATE: begin
              corner_d = '0;
              if (upd_ok) begin
                state_d = ST_UPD_RD;
              end
            end
            FUNC_FINISH: begin
              walk_d      = '0;
              col_idx_d   = '0;
              first_row_d = 1'b1;
              count_d     = '0;
              state_d     = ST_FIN_RD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_UPD_RD: begin
        diff_raddr = grid_addr(corner_row, corner_col);
        if (corner_ok) begin
          diff_re = 1'b1;
          state_d = ST_UPD_WR;
        end else begin
          corner_d = corner_q + 1'b1;
          if (corner_q == 2'd3) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_UPD_WR: begin
        diff_we    = 1'b1;
        diff_waddr = grid_addr(corner_row, corner_col);
        diff_wdata = alu_sum;
        corner_d   = corner_q + 1'b1;
        state_d    = (corner_q == 2'd3) ? ST_IDLE : ST_UPD_RD;
      end
      ST_FIN_RD: begin
        diff_re = 1'b1;
        cell_re = 1'b1;
        line_re = 1'b1;
        state_d = ST_FIN_ROW;
      end
      ST_FIN_ROW: begin
        // Running prefix sum along the current row.
        row_acc_d = alu_sum;
        state_d   = ST_FIN_COL;
      end
      ST_FIN_COL: begin
        // Column prefix: add the finished value of the row above.
        col_val_d = alu_sum;
        line_we   = 1'b1;
        state_d   = ST_FIN_CELL;
      end
      ST_FIN_CELL: begin
        // Update the cell, count it, and clear the difference entry.
        cell_we = 1'b1;
        diff_we = 1'b1;
        if (!alu_sum[DATA_W-1] && (alu_sum != '0) && (count_q != CNT_MAX)) begin
          count_d = count_q + 1'b1;
        end
        walk_d    = walk_q + 1'b1;
        col_idx_d = col_idx_q + 1'b1;
        if (col_idx_q == LAST_COL) begin
          col_idx_d   = '0;
          first_row_d = 1'b0;
        end
        if (walk_q == LAST_ADDR) begin
          result_d = count_d;
          done_d   = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_FIN_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      walk_q      <= '0;
      col_idx_q   <= '0;
      first_row_q <= 1'b1;
      corner_q    <= '0;
      count_q     <= '0;
      result_q    <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      col_idx_q   <= col_idx_d;
      first_row_q <= first_row_d;
      corner_q    <= corner_d;
      count_q     <= count_d;
      result_q    <= result_d;
      done_q      <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    row_acc_q <= row_acc_d;
    col_val_q <= col_val_d;
    if (accept) begin
      r1_q    <= crd_t'(row_i);
      c1_q    <= crd_t'(col_i);
      r2p_q   <= crd_t'(row_end_i) + 1'b1;
      c2p_q   <= crd_t'(col_end_i) + 1'b1;
      delta_q <= corner_neg ? -deg_ext : deg_ext;
    end
  end

  grpc_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_diff_ram (
    .clk_i   (clk_i),
    .we_i    (diff_we),
    .waddr_i (diff_waddr),
    .wdata_i (diff_wdata),
    .re_i    (diff_re),
    .raddr_i (diff_raddr),
    .rdata_o (diff_rdata)
  );

  grpc_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .re_i    (cell_re),
    .raddr_i (walk_q),
    .rdata_o (cell_rdata)
  );

  // One row of finished prefix values, used by the row below.
  grpc_ram #(.WIDTH(DATA_W), .DEPTH(COLS)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (col_idx_q),
    .wdata_i (alu_sum),
    .re_i    (line_re),
    .raddr_i (col_idx_q),
    .rdata_o (line_rdata)
  );

  assign done_o           = done_q;
  assign positive_count_o = result_q;

endmodule

### src/grpc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module grpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/grpc_sat_add.sv
// Shared 32-bit signed adder that clamps to the signed 32-bit range.
module grpc_sat_add (
  input  grpc_pkg::data_t a_i,
  input  grpc_pkg::data_t b_i,
  output grpc_pkg::data_t sum_o
);
  import grpc_pkg::*;

  logic [DATA_W:0] wide;

  // One extra bit exposes overflow; clamp toward the sign of the true sum.
  assign wide = {a_i[DATA_W-1], a_i} + {b_i[DATA_W-1], b_i};

  always_comb begin
    if (wide[DATA_W] != wide[DATA_W-1]) begin
      sum_o = wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sum_o = data_t'(wide[DATA_W-1:0]);
    end
  end

endmodule

### tb/sv/tb_grid_range_add_prefix_count_core.sv
// Self-checking testbench for the grid range-add prefix-count core.
module tb_grid_range_add_prefix_count_core;
  import grpc_pkg::*;

  // Function code that the block leaves without effect.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Saturation bounds of the 32-bit accumulators.
  localparam int SAT_HI = 32'h7FFF_FFFF;
  localparam int SAT_LO = 32'h8000_0000;

  // One command transaction as it appears on the input ports.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row_end;
    logic [IDX_W-1:0]  col_end;
    logic [VAL_W-1:0]  board_value;
    logic [VAL_W-1:0]  degree;
    logic              is_attack;
  } grid_op_t;

  // Shadow copy of the grid and difference grid, plus the counts still owed by the block.
  class grid_count_predictor;
    int                     cells [ROWS][COLS];
    int                     diffs [ROWS+1][COLS+1];
    logic [CNT_W-1:0]       expected_counts [$];
    int                     finishes;
    int                     ignored;
    int                     counts_checked;
    int                     errors;

    function int sat_add(int a, longint b);
      longint s;
      s = longint'(a) + b;
      if (s > longint'(SAT_HI)) return SAT_HI;
      if (s < longint'(SAT_LO)) return SAT_LO;
      return int'(s);
    endfunction

    // Apply one accepted transaction to the shadow state.
    function void note_item(grid_op_t op);
      int     r1, c1, r2, c2, n;
      longint d;
      r1 = int'(op.row);
      c1 = int'(op.col);
      r2 = int'(op.row_end);
      c2 = int'(op.col_end);
      case (op.func)
        FUNC_LOAD: begin
          if (r1 < ROWS && c1 < COLS) cells[r1][c1] = int'(op.board_value);
          else ignored++;
        end
        FUNC_UPDATE: begin
          if (r1 > r2 || c1 > c2 || r2 >= ROWS || c2 >= COLS) begin
            ignored++;
          end else begin
            d = longint'(op.degree);
            if (op.is_attack) d = -d;
            diffs[r1][c1]         = sat_add(diffs[r1][c1], d);
            diffs[r1][c2+1]       = sat_add(diffs[r1][c2+1], -d);
            diffs[r2+1][c1]       = sat_add(diffs[r2+1][c1], -d);
            diffs[r2+1][c2+1]     = sat_add(diffs[r2+1][c2+1], d);
          end
        end
        FUNC_FINISH: begin
          // Row prefix sums, then column prefix sums, then fold into the cells.
          n = 0;
          for (int i = 0; i < ROWS; i++)
            for (int j = 0; j < COLS; j++)
              diffs[i][j+1] = sat_add(diffs[i][j+1], diffs[i][j]);
          for (int j = 0; j < COLS; j++)
            for (int i = 0; i < ROWS; i++)
              diffs[i+1][j] = sat_add(diffs[i+1][j], diffs[i][j]);
          for (int i = 0; i < ROWS; i++)
            for (int j = 0; j < COLS; j++) begin
              cells[i][j] = sat_add(cells[i][j], diffs[i][j]);
              if (cells[i][j] >= 1 && n < int'(CNT_MAX)) n++;
            end
          for (int i = 0; i <= ROWS; i++)
            for (int j = 0; j <= COLS; j++)
              diffs[i][j] = 0;
          expected_counts.push_back(CNT_W'(n));
          finishes++;
        end
        default: ignored++;
      endcase
    endfunction

    // Compare one count strobe with the oldest outstanding finish.
    function void check_count(logic [CNT_W-1:0] got);
      logic [CNT_W-1:0] want;
      if (expected_counts.size() == 0) begin
        $error("positive_count: expected none, actual %0d", got);
        errors++;
        return;
      end
      want = expected_counts.pop_front();
      counts_checked++;
      if (got !== want) begin
        $error("positive_count: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [FUNC_W-1:0] func_i;
  logic [IDX_W-1:0]  row_i;
  logic [IDX_W-1:0]  col_i;
  logic [IDX_W-1:0]  row_end_i;
  logic [IDX_W-1:0]  col_end_i;
  logic [VAL_W-1:0]  board_value_i;
  logic [VAL_W-1:0]  degree_i;
  logic              is_attack_i;
  logic              done_o;
  logic [CNT_W-1:0]  positive_count_o;

  grid_count_predictor pred = new();
  int                  burst_left;
  int                  sent;

  grid_range_add_prefix_count_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .func_i           (func_i),
    .row_i            (row_i),
    .col_i            (col_i),
    .row_end_i        (row_end_i),
    .col_end_i        (col_end_i),
    .board_value_i    (board_value_i),
    .degree_i         (degree_i),
    .is_attack_i      (is_attack_i),
    .done_o           (done_o),
    .positive_count_o (positive_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Every count strobe is checked at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) pred.check_count(positive_count_o);
  end

  // Values skewed toward 0, 1, the top of the range and small magnitudes.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return VAL_W'(1);
      2:       return '1;
      3, 4:    return VAL_W'($urandom_range(1, 4));
      default: return VAL_W'($urandom());
    endcase
  endfunction

  // Fully random transaction; callers overwrite the fields that matter.
  function automatic grid_op_t random_op();
    grid_op_t op;
    op.func        = FUNC_W'($urandom());
    op.row         = IDX_W'($urandom());
    op.col         = IDX_W'($urandom());
    op.row_end     = IDX_W'($urandom());
    op.col_end     = IDX_W'($urandom());
    op.board_value = VAL_W'($urandom());
    op.degree      = VAL_W'($urandom());
    op.is_attack   = 1'($urandom());
    return op;
  endfunction

  function automatic grid_op_t rect_op(int r1, int c1, int r2, int c2, int deg, bit atk);
    grid_op_t op;
    op           = random_op();
    op.func      = FUNC_UPDATE;
    op.row       = IDX_W'(r1);
    op.col       = IDX_W'(c1);
    op.row_end   = IDX_W'(r2);
    op.col_end   = IDX_W'(c2);
    op.degree    = VAL_W'(deg);
    op.is_attack = atk;
    return op;
  endfunction

  // Present one transaction and hold it until the block takes it.
  task automatic drive_op(input grid_op_t op);
    @(negedge clk_i);
    start_i       <= 1'b1;
    func_i        <= op.func;
    row_i         <= op.row;
    col_i         <= op.col;
    row_end_i     <= op.row_end;
    col_end_i     <= op.col_end;
    board_value_i <= op.board_value;
    degree_i      <= op.degree;
    is_attack_i   <= op.is_attack;
    do @(posedge clk_i); while (busy_o);
    pred.note_item(op);
    sent++;
  endtask

  // Random gap between transactions: mostly none or short, a few long, some back-to-back bursts.
  task automatic idle_source(input int longest);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (roll == 99) begin
      burst_left = $urandom_range(10, 40);
      gap = 0;
    end else if (roll < 50) begin
      gap = 0;
    end else if (roll < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(4, longest);
    end
    if (gap > 0) begin
      @(negedge clk_i);
      start_i   <= 1'b0;
      func_i    <= FUNC_W'($urandom());
      degree_i  <= VAL_W'($urandom());
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  initial begin
    grid_op_t op;
    int       useful;
    int       roll;
    bit       counts;

    rst_ni        = 1'b0;
    start_i       = 1'b0;
    func_i        = FUNC_LOAD;
    row_i         = '0;
    col_i         = '0;
    row_end_i     = '0;
    col_end_i     = '0;
    board_value_i = '0;
    degree_i      = '0;
    is_attack_i   = 1'b0;
    burst_left    = 0;
    sent          = 0;
    useful        = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Load every cell first, since a finish reads the whole grid.
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++) begin
        op             = random_op();
        op.func        = FUNC_LOAD;
        op.row         = IDX_W'(r);
        op.col         = IDX_W'(c);
        op.board_value = pick_value();
        drive_op(op);
        idle_source(6);
      end

    // Directed transactions: full grid, far corner, single row and column,
    // rejected rectangles, zero degree, the unused code and the extreme loads.
    drive_op(rect_op(0, 0, 63, 63, 16'hFFFF, 1'b0));
    drive_op(rect_op(63, 63, 63, 63, 16'hFFFF, 1'b1));
    drive_op(rect_op(0, 0, 0, 0, 1, 1'b0));
    drive_op(rect_op(5, 0, 5, 63, 3, 1'b1));
    drive_op(rect_op(0, 17, 63, 17, 1, 1'b1));
    drive_op(rect_op(10, 0, 9, 63, 100, 1'b0));
    drive_op(rect_op(0, 40, 63, 39, 100, 1'b0));
    drive_op(rect_op(20, 20, 30, 30, 0, 1'b1));
    op = '1;
    op.func = FUNC_UNUSED;
    drive_op(op);
    op = '0;
    op.func = FUNC_FINISH;
    drive_op(op);
    op = '0;
    op.func = FUNC_LOAD;
    drive_op(op);
    op.row = 63;
    op.col = 63;
    op.board_value = '1;
    drive_op(op);
    op.row = 0;
    op.board_value = 1;
    drive_op(op);
    op.row = 63;
    op.col = 0;
    drive_op(op);
    drive_op(rect_op(0, 0, 63, 63, 1, 1'b1));
    drive_op(rect_op(0, 0, 63, 63, 16'hFFFF, 1'b1));
    op = '1;
    op.func = FUNC_FINISH;
    drive_op(op);

    // Random part: mostly loads and valid rectangles, some finishes, rejected ones and noise.
    while (useful < 400 || pred.finishes < 32) begin
      op     = random_op();
      roll   = $urandom_range(0, 99);
      counts = 1'b1;
      if (pred.finishes < 38 && $urandom_range(0, 12) == 0) begin
        op.func = FUNC_FINISH;
      end else if (roll < 35) begin
        op.func        = FUNC_LOAD;
        op.board_value = pick_value();
      end else if (roll < 90) begin
        op.func   = FUNC_UPDATE;
        op.degree = pick_value();
        if ($urandom_range(0, 1)) begin
          op.row_end = (op.row > 60) ? IDX_W'(63) : IDX_W'(op.row + $urandom_range(0, 3));
          op.col_end = (op.col > 60) ? IDX_W'(63) : IDX_W'(op.col + $urandom_range(0, 3));
        end else begin
          op.row_end = IDX_W'($urandom_range(63, int'(op.row)));
          op.col_end = IDX_W'($urandom_range(63, int'(op.col)));
        end
      end else if (roll < 97) begin
        op.func = FUNC_UPDATE;
        counts  = 1'b0;
        if ($urandom_range(0, 1)) begin
          op.row     = IDX_W'($urandom_range(1, 63));
          op.row_end = IDX_W'($urandom_range(0, int'(op.row) - 1));
        end else begin
          op.col     = IDX_W'($urandom_range(1, 63));
          op.col_end = IDX_W'($urandom_range(0, int'(op.col) - 1));
        end
      end else begin
        op.func = FUNC_UNUSED;
        counts  = 1'b0;
      end
      drive_op(op);
      if (counts) useful++;
      idle_source(40);
    end

    @(negedge clk_i);
    start_i <= 1'b0;

    // Drain outstanding counts, then give the block time for any stray strobe.
    while (pred.pending() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Drove %0d transactions after a full-grid preload; %0d were rejected or unused.",
             sent, pred.ignored);
    $display("Compared %0d positive counts from %0d finish transactions.",
             pred.counts_checked, pred.finishes);
    if (pred.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
